/* src/ldqm_pkg.sv */
// ----------------------------------------------------------------------------
// ldqm_pkg
// Shared types and constants of the latency / deadline QoS monitor.
// ----------------------------------------------------------------------------
package ldqm_pkg;

  localparam int unsigned TS_W    = 64;  // timestamp width
  localparam int unsigned LAT_W   = 32;  // latency, jitter, deadline width
  localparam int unsigned Q_FRAC  = 16;  // fractional bits of a Q1.16 score
  localparam int unsigned SCORE_W = 17;  // Q1.16 score width, 1.0 included
  localparam int unsigned APB_AW  = 3;   // byte address width of the APB port
  localparam int unsigned APB_DW  = 32;

  localparam logic [SCORE_W-1:0] Q_ONE        = SCORE_W'(1) << Q_FRAC;
  localparam logic [LAT_W-1:0]   DEADLINE_RST = 32'd100000;

  // register word index (byte address / 4)
  localparam logic REG_DEADLINE = 1'b0;

  typedef struct packed {
    logic [TS_W-1:0] detect_time;
    logic [TS_W-1:0] act_time;
  } in_beat_t;

  typedef struct packed {
    logic [LAT_W-1:0]   latency_us;
    logic               on_time;
    logic [LAT_W-1:0]   jitter;
    logic [SCORE_W-1:0] score;
    logic [SCORE_W-1:0] average_qos;
  } out_beat_t;

  // controller -> datapath commands, at most one high per cycle
  typedef struct packed {
    logic capture;     // latch latency from the accepted beat
    logic prep;        // deadline compare, jitter, score divider setup
    logic score_step;  // one restoring step of the score division
    logic update;      // ring write, running sum, count, position
    logic avg_step;    // one restoring step of the average division
    logic publish;     // load the output register
  } ctrl_cmd_t;

endpackage

/* src/ldqm_ctrl.sv */
// ----------------------------------------------------------------------------
// ldqm_ctrl
// Sequencer: accept, prepare, score division, ring update, average
// division, publish. Owns the handshake flags and the step counter.
// ----------------------------------------------------------------------------
module ldqm_ctrl #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ldqm_pkg::ctrl_cmd_t cmd_o
);

  localparam int unsigned SUMW = ldqm_pkg::SCORE_W + $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ITW  = $clog2(SUMW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SDIV = 3'd2;
  localparam logic [2:0] S_UPDT = 3'd3;
  localparam logic [2:0] S_ADIV = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [ITW-1:0] iter_q, iter_d;
  logic           out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        iter_d     = ITW'(ldqm_pkg::Q_FRAC - 1);
        state_d    = S_SDIV;
      end
      S_SDIV: begin
        cmd_o.score_step = 1'b1;
        iter_d           = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = S_UPDT;
        end
      end
      S_UPDT: begin
        cmd_o.update = 1'b1;
        iter_d       = ITW'(SUMW - 1);
        state_d      = S_ADIV;
      end
      S_ADIV: begin
        cmd_o.avg_step = 1'b1;
        iter_d         = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/ldqm_datapath.sv */
// ----------------------------------------------------------------------------
// ldqm_datapath
// Latency, deadline check, jitter, two restoring dividers, score ring with
// running sum, deadline register and the output register.
// ----------------------------------------------------------------------------
module ldqm_datapath #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ldqm_pkg::ctrl_cmd_t                cmd_i,
  input  ldqm_pkg::in_beat_t                 in_data_i,
  input  logic                               cfg_we_i,
  input  logic [ldqm_pkg::LAT_W-1:0]         cfg_wdata_i,
  output logic [ldqm_pkg::LAT_W-1:0]         deadline_o,
  output ldqm_pkg::out_beat_t                out_data_o
);

  localparam int unsigned LW   = ldqm_pkg::LAT_W;
  localparam int unsigned SW   = ldqm_pkg::SCORE_W;
  localparam int unsigned PW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUMW = SW + CNTW;

  // configuration and history state
  logic [LW-1:0]   deadline_q;
  logic [LW-1:0]   prev_lat_q;
  logic [PW-1:0]   pos_q;
  logic [CNTW-1:0] cnt_q;
  logic [SUMW-1:0] sum_q, sum_d;
  logic            full;

  // per-event working registers
  logic [LW-1:0]   lat_q;
  logic            met_q;
  logic [LW-1:0]   jit_q;
  logic [LW-1:0]   dsor_q;
  logic [LW-1:0]   srem_q;
  logic [SW-1:0]   squo_q;
  logic [SUMW-1:0] ashift_q;
  logic [CNTW-1:0] arem_q;
  logic [SW-1:0]   aquo_q;

  // score ring
  logic [SW-1:0]   ring [HISTORY_DEPTH];
  logic [SW-1:0]   old_q;

  logic [LW-1:0]   d_eff;
  logic [LW:0]     srem2;
  logic            sbit;
  logic [CNTW:0]   arem2;
  logic            abit;
  ldqm_pkg::out_beat_t out_q;

  assign full  = (cnt_q == CNTW'(HISTORY_DEPTH));
  assign d_eff = (deadline_q == '0) ? LW'(1) : deadline_q;

  assign srem2 = {srem_q, 1'b0};
  assign sbit  = (srem2 >= {1'b0, dsor_q});

  assign arem2 = {arem_q, ashift_q[SUMW-1]};
  assign abit  = (arem2 >= {1'b0, cnt_q});

  assign sum_d = sum_q - (full ? SUMW'(old_q) : '0) + SUMW'(squo_q);

  // ring memory: one write port, one registered read at the current slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring[pos_q] <= squo_q;
    end
    old_q <= ring[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= ldqm_pkg::DEADLINE_RST;
      prev_lat_q <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        deadline_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        prev_lat_q <= lat_q;
        sum_q      <= sum_d;
        pos_q      <= (pos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        if (!full) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lat_q <= in_data_i.act_time[LW-1:0] - in_data_i.detect_time[LW-1:0];
    end
    if (cmd_i.prep) begin
      met_q  <= (lat_q <= deadline_q);
      jit_q  <= (cnt_q == '0)        ? '0 :
                (lat_q > prev_lat_q) ? lat_q - prev_lat_q : prev_lat_q - lat_q;
      dsor_q <= d_eff;
      if (lat_q >= d_eff) begin
        srem_q <= '0;
        squo_q <= '0;
      end else if (lat_q == '0) begin
        // full score: a seed bit shifts up to 1.0 over the steps
        srem_q <= '0;
        squo_q <= SW'(1);
      end else begin
        srem_q <= d_eff - lat_q;
        squo_q <= '0;
      end
    end
    if (cmd_i.score_step) begin
      // remainder stays below the divisor, so it fits in LW bits
      srem_q <= sbit ? LW'(srem2 - {1'b0, dsor_q}) : srem2[LW-1:0];
      squo_q <= {squo_q[SW-2:0], sbit};
    end
    if (cmd_i.update) begin
      ashift_q <= sum_d;
      arem_q   <= '0;
      aquo_q   <= '0;
    end
    if (cmd_i.avg_step) begin
      // the mean never exceeds 1.0, so SW quotient bits are enough
      arem_q   <= abit ? CNTW'(arem2 - {1'b0, cnt_q}) : CNTW'(arem2);
      ashift_q <= {ashift_q[SUMW-2:0], 1'b0};
      aquo_q   <= {aquo_q[SW-2:0], abit};
    end
    if (cmd_i.publish) begin
      out_q.latency_us  <= lat_q;
      out_q.on_time     <= met_q;
      out_q.jitter      <= jit_q;
      out_q.score       <= squo_q;
      out_q.average_qos <= aquo_q;
    end
  end

  assign deadline_o = deadline_q;
  assign out_data_o = out_q;

endmodule

/* src/latency_deadline_qos_monitor.sv */
// ----------------------------------------------------------------------------
// latency_deadline_qos_monitor
// Per-event latency, deadline check, jitter and Q1.16 QoS score, with a
// running mean of the scores kept over a ring of HISTORY_DEPTH events.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | in        | in_valid_i/in_ready_o  | in_data_i  (detect, act)
//  out     | out       | out_valid_o/out_ready_i| out_data_o (lat..avg)
//  apb     | in        | psel/penable, pready   | paddr, pwdata, prdata
//
//  One event at a time. The input reopens in the same cycle that the result
//  becomes valid: the score divider retires one quotient bit per cycle over
//  16 steps, then the average divider one bit per cycle over the running-sum
//  width, SUMW = 17 + clog2(HISTORY_DEPTH+1).
//  A new beat is taken while the previous result waits in the output
//  register; the finished event then stalls until that result is taken.
//  Reset clears the sequencer, count, position and sum; the ring itself is
//  never cleared, only slots already written are ever read back.
//
module latency_deadline_qos_monitor #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // event input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ldqm_pkg::in_beat_t              in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ldqm_pkg::out_beat_t             out_data_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ldqm_pkg::APB_AW-1:0]     paddr,
  input  logic [ldqm_pkg::APB_DW-1:0]     pwdata,
  output logic [ldqm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  ldqm_pkg::ctrl_cmd_t             cmd;
  logic [ldqm_pkg::LAT_W-1:0]      deadline;
  logic                            reg_hit;
  logic                            cfg_we;

  // APB: zero wait states, one register at word 0
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ldqm_pkg::APB_AW-1] == ldqm_pkg::REG_DEADLINE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? deadline : '0;

  ldqm_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ldqm_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata),
    .deadline_o  (deadline),
    .out_data_o  (out_data_o)
  );

  // a nonzero score implies the deadline was met
  a_score_met : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.score != '0)) |-> out_data_o.on_time)
    else $error("nonzero QoS score on a missed deadline");

  // scores and their mean never exceed 1.0
  a_score_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.score <= ldqm_pkg::Q_ONE) &&
                     (out_data_o.average_qos <= ldqm_pkg::Q_ONE)))
    else $error("QoS score above 1.0");

  // one event in flight: an accepted beat closes the input
  a_one_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened right after accept");

endmodule
